FILE: src/rocc_pkg.sv
// shared types, constants and register indexes of the room occupancy block
package rocc_pkg;

	// default width of the tick-age counters
	localparam int AGE_WIDTH_DEF = 16;

	// configuration register widths and reset values
	localparam int HOLD_W = 16;
	localparam int TICK_W = 8;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [HOLD_W-1:0] MOTION_HOLD_RST = 16'd45;
	localparam logic [HOLD_W-1:0] MOTION_HOLD_CLOSED_RST = 16'd900;
	localparam logic [TICK_W-1:0] BLOCK_AFTER_CLOSE_RST = 8'd4;
	localparam logic [TICK_W-1:0] EXPECT_MOTION_RST = 8'd10;
	localparam logic [TICK_W-1:0] PRESS_VALID_RST = 8'd30;
	localparam logic [TICK_W-1:0] PRIVATE_DOOR_OPEN_RST = 8'd7;
	localparam logic [TICK_W-1:0] RECENT_MOTION_RST = 8'd2;

	// private door-open counter saturates here
	localparam logic [TICK_W-1:0] PRIV_CNT_MAX = 8'd255;

	// register indexes on the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MOTION_HOLD        = 3'd0,
		REG_MOTION_HOLD_CLOSED = 3'd1,
		REG_BLOCK_AFTER_CLOSE  = 3'd2,
		REG_EXPECT_MOTION      = 3'd3,
		REG_PRESS_VALID        = 3'd4,
		REG_PRIVATE_DOOR_OPEN  = 3'd5,
		REG_RECENT_MOTION      = 3'd6
	} reg_idx_t;

	// room mode
	typedef enum logic [1:0] {
		MODE_EMPTY    = 2'd0,
		MODE_OPEN_USE = 2'd1,
		MODE_IN_USE   = 2'd2,
		MODE_PRIVATE  = 2'd3
	} mode_t;

	// configuration values seen by the tick logic
	typedef struct packed {
		logic [HOLD_W-1:0] motion_hold;
		logic [HOLD_W-1:0] motion_hold_closed;
		logic [TICK_W-1:0] block_after_close;
		logic [TICK_W-1:0] expect_motion;
		logic [TICK_W-1:0] press_valid;
		logic [TICK_W-1:0] private_door_open;
		logic [TICK_W-1:0] recent_motion;
	} cfg_t;

	// one tick of sensor input
	typedef struct packed {
		logic button_pulse;
		logic door_shut;
		logic motion_level;
	} tick_t;

	// one result, packed lowest field in the lowest bits
	typedef struct packed {
		logic  door_open_flag;
		logic  occupied_flag;
		logic  private_flag;
		logic  red_led;
		logic  yellow_blink;
		logic  yellow_led;
		logic  green_led;
		mode_t room_mode;
	} result_t;

endpackage

FILE: src/rocc_cfg.sv
// configuration register bank of the room occupancy block
module rocc_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [rocc_pkg::CFG_IDX_W-1:0]     wr_index,
	input  logic [rocc_pkg::CFG_DATA_W-1:0]    wr_data,
	output rocc_pkg::cfg_t                     cfg
);
	import rocc_pkg::*;

	cfg_t cfg_q;

	// register writes, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.motion_hold        <= MOTION_HOLD_RST;
			cfg_q.motion_hold_closed <= MOTION_HOLD_CLOSED_RST;
			cfg_q.block_after_close  <= BLOCK_AFTER_CLOSE_RST;
			cfg_q.expect_motion      <= EXPECT_MOTION_RST;
			cfg_q.press_valid        <= PRESS_VALID_RST;
			cfg_q.private_door_open  <= PRIVATE_DOOR_OPEN_RST;
			cfg_q.recent_motion      <= RECENT_MOTION_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_MOTION_HOLD:        cfg_q.motion_hold <= wr_data[HOLD_W-1:0];
				REG_MOTION_HOLD_CLOSED: cfg_q.motion_hold_closed <= wr_data[HOLD_W-1:0];
				REG_BLOCK_AFTER_CLOSE:  cfg_q.block_after_close <= wr_data[TICK_W-1:0];
				REG_EXPECT_MOTION:      cfg_q.expect_motion <= wr_data[TICK_W-1:0];
				REG_PRESS_VALID:        cfg_q.press_valid <= wr_data[TICK_W-1:0];
				REG_PRIVATE_DOOR_OPEN:  cfg_q.private_door_open <= wr_data[TICK_W-1:0];
				REG_RECENT_MOTION:      cfg_q.recent_motion <= wr_data[TICK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/rocc_core.sv
// per-tick state update and mode transition of the room occupancy block
module rocc_core #(
	parameter int AGE_WIDTH = rocc_pkg::AGE_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  rocc_pkg::tick_t   tick,
	input  rocc_pkg::cfg_t    cfg,
	output rocc_pkg::result_t result,
	output rocc_pkg::mode_t   mode
);
	import rocc_pkg::*;

	// compare width wide enough for both ages and hold thresholds
	localparam int CW = (AGE_WIDTH > HOLD_W) ? AGE_WIDTH : HOLD_W;
	localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};

	mode_t                mode_q, mode_n;
	logic [AGE_WIDTH-1:0] motion_age_q, motion_age_n;
	logic [AGE_WIDTH-1:0] closed_age_q, closed_age_n;
	logic [AGE_WIDTH-1:0] press_age_q, press_age_n;
	logic                 seen_q, seen_n;
	logic                 pend_q, pend_n;
	logic [TICK_W-1:0]    priv_cnt_q, priv_cnt_n;

	function automatic logic [AGE_WIDTH-1:0] age_inc(input logic [AGE_WIDTH-1:0] a);
		return (a == AGE_MAX) ? a : a + 1'b1;
	endfunction

	// next state for the tick in the input stage
	always_comb begin
		logic          shut;
		logic          expected;
		logic          hold_closed_exp;
		logic          hold_open_exp;
		logic [CW-1:0] m_ext;
		logic [CW-1:0] c_ext;
		logic [CW-1:0] blk_ext;
		logic [TICK_W-1:0] cnt_inc;

		shut = tick.door_shut;

		// ages first
		motion_age_n = tick.motion_level ? '0 : age_inc(motion_age_q);
		closed_age_n = shut ? age_inc(closed_age_q) : '0;

		// press capture and expiry
		pend_n = pend_q | tick.button_pulse;
		if (tick.button_pulse) begin
			press_age_n = '0;
		end else if (pend_q) begin
			press_age_n = age_inc(press_age_q);
		end else begin
			press_age_n = press_age_q;
		end
		if (pend_n && (CW'(press_age_n) > CW'(cfg.press_valid))) begin
			pend_n = 1'b0;
		end

		m_ext   = CW'(motion_age_n);
		c_ext   = CW'(closed_age_n);
		blk_ext = CW'(cfg.block_after_close);

		expected = shut && (c_ext > CW'(cfg.expect_motion));

		// motion seen after the close blanking window
		if (shut) begin
			seen_n = seen_q | ((c_ext >= blk_ext) && (m_ext < (c_ext - blk_ext)));
		end else begin
			seen_n = 1'b0;
		end

		hold_open_exp   = m_ext > CW'(cfg.motion_hold);
		hold_closed_exp = m_ext > CW'(cfg.motion_hold_closed);
		cnt_inc = (priv_cnt_q == PRIV_CNT_MAX) ? priv_cnt_q : priv_cnt_q + 1'b1;

		mode_n     = mode_q;
		priv_cnt_n = priv_cnt_q;

		// mode transition, later checks override earlier ones, but in use a pending press wins
		unique case (mode_q)
			MODE_EMPTY: begin
				if (m_ext < CW'(cfg.recent_motion)) mode_n = MODE_OPEN_USE;
			end
			MODE_OPEN_USE: begin
				if (shut && seen_n) mode_n = MODE_IN_USE;
				if (hold_open_exp) mode_n = MODE_EMPTY;
				if (pend_n) begin
					pend_n = 1'b0;
					mode_n = MODE_PRIVATE;
				end
				if (expected && !seen_n) mode_n = MODE_EMPTY;
			end
			MODE_IN_USE: begin
				if (pend_n) begin
					pend_n = 1'b0;
					mode_n = MODE_PRIVATE;
				end else begin
					if (!shut) mode_n = MODE_OPEN_USE;
					if ((seen_n && hold_closed_exp) || (!seen_n && hold_open_exp)) begin
						mode_n = MODE_EMPTY;
					end
				end
			end
			MODE_PRIVATE: begin
				if (!shut) begin
					priv_cnt_n = cnt_inc;
					if (cnt_inc >= cfg.private_door_open) mode_n = MODE_OPEN_USE;
				end else begin
					priv_cnt_n = '0;
				end
				if (hold_closed_exp || (expected && !seen_n)) mode_n = MODE_EMPTY;
				if (pend_n) begin
					pend_n = 1'b0;
					mode_n = MODE_IN_USE;
				end
			end
			default: begin
			end
		endcase
	end

	// state registers, advanced once per tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_EMPTY;
			motion_age_q <= AGE_MAX;
			closed_age_q <= '0;
			press_age_q  <= '0;
			seen_q       <= 1'b0;
			pend_q       <= 1'b0;
			priv_cnt_q   <= '0;
		end else if (step) begin
			mode_q       <= mode_n;
			motion_age_q <= motion_age_n;
			closed_age_q <= closed_age_n;
			press_age_q  <= press_age_n;
			seen_q       <= seen_n;
			pend_q       <= pend_n;
			priv_cnt_q   <= priv_cnt_n;
		end
	end

	// indicator decode of the new mode
	always_comb begin
		result.room_mode      = mode_n;
		result.green_led      = (mode_n == MODE_EMPTY);
		result.yellow_led     = (mode_n == MODE_IN_USE);
		result.yellow_blink   = (mode_n == MODE_OPEN_USE);
		result.red_led        = (mode_n == MODE_PRIVATE);
		result.private_flag   = (mode_n == MODE_PRIVATE);
		result.occupied_flag  = (mode_n != MODE_EMPTY);
		result.door_open_flag = ~tick.door_shut;
	end

	assign mode = mode_q;

endmodule

FILE: src/room_occupancy_state_machine_top.sv
// Room occupancy state machine, one request per one-second tick.
//
// Input stream s_*: s_tdata carries one tick of sensor data (motion level,
// debounced door state, button press pulse). Output stream m_*: m_tdata
// carries the resulting mode, indicator LEDs and status flags, one result
// for every tick accepted.
// Configuration port cfg_*: cfg_index picks one of seven threshold
// registers, cfg_data is the value; always ready. Write only while no tick
// is in flight; the block does not enforce this. Unknown indexes are ignored.
//
// Path: a tick is held in the input register, the state update and mode
// decode run as combinational logic, and the result is loaded into the
// output register, which drives m_tdata.
// Throughput: one tick per cycle while the output is not stalled on m_tready;
// the state registers are updated once for every tick processed.
// A stall on m_tready holds the result; the input register still takes one
// more tick, then s_tready drops until the result is taken.
// Reset: asynchronous, clears both stages, sets mode to empty, the motion
// age to saturated and loads the register defaults.
module room_occupancy_state_machine_top #(
	parameter int AGE_WIDTH = rocc_pkg::AGE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,  // motion_level, door_shut, button_pulse
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// room_mode[1:0], green_led, yellow_led, yellow_blink, red_led, private_flag,
	// occupied_flag, door_open_flag
	output logic [15:0]                         m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [rocc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rocc_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import rocc_pkg::*;

	localparam int RES_W = $bits(result_t);

	cfg_t    cfg;
	logic    valid_s1;
	tick_t   tick_s1;
	logic    valid_s2;
	result_t res_s2;
	result_t res_n;
	mode_t   mode_cur;
	logic    advance;

	assign cfg_ready = 1'b1;

	rocc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// tick in stage 1 moves on when the output register is free
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tick_s1 <= tick_t'(s_tdata[2:0]);
		end
	end

	rocc_core #(
		.AGE_WIDTH (AGE_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.tick   (tick_s1),
		.cfg    (cfg),
		.result (res_n),
		.mode   (mode_cur)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_n;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(16 - RES_W){1'b0}}, res_s2};

	// exactly one indicator lit on a shown result
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> $onehot({res_s2.green_led, res_s2.yellow_led,
			res_s2.yellow_blink, res_s2.red_led}))
		else $error("indicator LEDs not one-hot");

	// mode only moves when a tick is processed
	assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(mode_cur))
		else $error("mode changed without a tick");

	// a loaded result carries the mode the state machine took
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (res_s2.room_mode == mode_cur))
		else $error("result mode differs from state");

	// a held result is not replaced while the receiver stalls
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !m_tready) |=> (valid_s2 && $stable(res_s2)))
		else $error("stalled result lost");

endmodule
